// ===== src/radio_enable_idle_sequencer_unit_defines.svh =====
// Assertion macros shared by the radio enable sequencer RTL.
// No dependencies; included by the files that carry assertions.
`ifndef RADIO_ENABLE_IDLE_SEQUENCER_UNIT_DEFINES_SVH
`define RADIO_ENABLE_IDLE_SEQUENCER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset
`define RESQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset
`define RESQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define RESQ_ASSERT(lbl, clk, rst_n, prop, msg)

`define RESQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== src/resq_pkg.sv =====
// Types and constants of the radio enable idle sequencer.
// No dependencies; used by resq_seq and the top level.
`timescale 1ns / 1ps
`default_nettype none

package resq_pkg;

    // Sequencer modes
    typedef enum logic [1:0] {
        MODE_OFF     = 2'd0,
        MODE_ARMING  = 2'd1,
        MODE_SERVING = 2'd2
    } mode_t;

    // Stop reason codes
    typedef enum logic [2:0] {
        STOP_NONE       = 3'd0,
        STOP_ENGINE     = 3'd1,
        STOP_DISABLED   = 3'd2,
        STOP_BATTERY    = 3'd3,
        STOP_IDLE       = 3'd4,
        STOP_START_FAIL = 3'd5
    } stop_t;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SERVICE_ENABLED = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RPM_THRESHOLD   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_BATTERY     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ARM_DELAY       = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDLE_TIMEOUT    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_POLL_INTERVAL   = 3'd5;

    // Reset values of the configuration registers
    localparam logic [13:0] RST_RPM_THRESHOLD = 14'd400;
    localparam logic [14:0] RST_MIN_BATTERY   = 15'd11500;
    localparam logic [31:0] RST_ARM_DELAY     = 32'd10000;
    localparam logic [31:0] RST_IDLE_TIMEOUT  = 32'd600000;
    localparam logic [15:0] RST_POLL_INTERVAL = 16'd1000;

    // Divide by 1000 as multiply by reciprocal and shift, exact for 32-bit values
    localparam int          RECIP_BITS  = 29;
    localparam logic [28:0] RECIP_1000  = 29'd274877907;
    localparam int          RECIP_SHIFT = 38;
    localparam int          PROD_BITS   = 32 + RECIP_BITS;

    typedef struct packed {
        logic        service_enabled;
        logic [13:0] running_rpm_threshold;
        logic [14:0] min_battery_mv;
        logic [31:0] arm_delay_ms;
        logic [31:0] idle_timeout_ms;
        logic [15:0] poll_interval_ms;
    } cfg_t;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        link_offline;
        logic [13:0] engine_rpm;
        logic [14:0] battery_mv;
        logic [3:0]  station_count;
        logic        start_ok;
    } tick_item_t;

    typedef struct packed {
        logic [1:0]  radio_state;
        logic        start_request;
        logic [2:0]  stop_reason;
        logic [22:0] idle_seconds_left;
        logic [3:0]  client_count;
    } result_item_t;

    // Sequencer stage to divider stage
    typedef struct packed {
        mode_t       radio_state;
        logic        start_request;
        stop_t       stop_reason;
        logic [3:0]  client_count;
        logic        left_valid;
        logic [31:0] left_ms;
    } step_t;

endpackage

`default_nettype wire

// ===== src/resq_if.sv =====
// Valid/ready channel carrying one item of a given payload type.
// Payload types come from resq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface resq_if #(
    parameter type item_t = logic
) ();

    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

`default_nettype wire

// ===== src/resq_seq.sv =====
// Off / arming / serving sequencer: holds the sequencer state and computes
// one step per item. Depends on resq_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "radio_enable_idle_sequencer_unit_defines.svh"

module resq_seq #(
    parameter int TIME_BITS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire resq_pkg::tick_item_t item,
    input  wire resq_pkg::cfg_t     cfg,
    output resq_pkg::step_t         step
);

    localparam int WIDE = (TIME_BITS > 32) ? TIME_BITS : 32;

    resq_pkg::mode_t        mode_reg, mode_next;
    logic [TIME_BITS-1:0]   since_reg, since_next;
    logic                   since_valid_reg, since_valid_next;
    logic                   latch_reg, latch_next;
    logic [TIME_BITS-1:0]   poll_reg, poll_next;
    logic [TIME_BITS-1:0]   client_reg, client_next;
    logic [3:0]             seen_reg, seen_next;

    logic [WIDE-1:0]        now_wide;
    logic [TIME_BITS-1:0]   now_t;
    logic [TIME_BITS-1:0]   since_eff;
    logic                   engine_stopped;
    logic                   arm_done;
    logic                   poll_due;
    logic                   idle_done;
    logic [TIME_BITS-1:0]   el_old;
    logic [TIME_BITS-1:0]   el_new;
    logic [WIDE-1:0]        el_wide;
    resq_pkg::stop_t        reason;
    logic                   start_req;

    // Time base and parallel elapsed-time compares
    assign now_wide  = WIDE'(item.now_ms);
    assign now_t     = now_wide[TIME_BITS-1:0];
    assign since_eff = (mode_reg == resq_pkg::MODE_OFF && !since_valid_reg) ? now_t : since_reg;
    assign engine_stopped = item.link_offline || (item.engine_rpm < cfg.running_rpm_threshold);
    assign arm_done  = WIDE'(TIME_BITS'(now_t - since_eff)) >= WIDE'(cfg.arm_delay_ms);
    assign poll_due  = WIDE'(TIME_BITS'(now_t - poll_reg)) >= WIDE'(cfg.poll_interval_ms);
    assign el_old    = TIME_BITS'(now_t - client_reg);
    assign idle_done = WIDE'(el_old) >= WIDE'(cfg.idle_timeout_ms);

    // Next state and step outputs
    always_comb
    begin
        mode_next        = mode_reg;
        since_next       = since_reg;
        since_valid_next = since_valid_reg;
        latch_next       = latch_reg;
        poll_next        = poll_reg;
        client_next      = client_reg;
        seen_next        = seen_reg;
        reason           = resq_pkg::STOP_NONE;
        start_req        = 1'b0;

        if (!engine_stopped)
        begin
            since_next       = now_t;
            since_valid_next = 1'b1;
            latch_next       = 1'b0;
            reason           = (mode_reg != resq_pkg::MODE_OFF) ? resq_pkg::STOP_ENGINE
                                                                : resq_pkg::STOP_NONE;
            mode_next        = resq_pkg::MODE_OFF;
            seen_next        = 4'd0;
        end
        else if (!cfg.service_enabled)
        begin
            reason    = (mode_reg != resq_pkg::MODE_OFF) ? resq_pkg::STOP_DISABLED
                                                         : resq_pkg::STOP_NONE;
            mode_next = resq_pkg::MODE_OFF;
            seen_next = 4'd0;
        end
        else if (!item.link_offline && item.battery_mv < cfg.min_battery_mv)
        begin
            reason    = (mode_reg != resq_pkg::MODE_OFF) ? resq_pkg::STOP_BATTERY
                                                         : resq_pkg::STOP_NONE;
            mode_next = resq_pkg::MODE_OFF;
            seen_next = 4'd0;
        end
        else
        begin
            case (mode_reg)
                resq_pkg::MODE_OFF, resq_pkg::MODE_ARMING:
                begin
                    if (mode_reg == resq_pkg::MODE_ARMING || !latch_reg)
                    begin
                        // Settle timer runs from the last running tick, or from now if none was seen
                        since_next       = since_eff;
                        since_valid_next = 1'b1;
                        mode_next        = resq_pkg::MODE_ARMING;
                        if (arm_done)
                        begin
                            start_req = 1'b1;
                            if (item.start_ok)
                            begin
                                mode_next   = resq_pkg::MODE_SERVING;
                                seen_next   = 4'd0;
                                client_next = now_t;
                            end
                            else
                            begin
                                mode_next = resq_pkg::MODE_OFF;
                                reason    = resq_pkg::STOP_START_FAIL;
                            end
                        end
                    end
                end
                default:
                begin
                    // Sample stations once per poll interval
                    if (poll_due)
                    begin
                        poll_next = now_t;
                        seen_next = item.station_count;
                        if (item.station_count != 4'd0)
                        begin
                            client_next = now_t;
                        end
                        else if (idle_done)
                        begin
                            latch_next = 1'b1;
                            reason     = resq_pkg::STOP_IDLE;
                            mode_next  = resq_pkg::MODE_OFF;
                            seen_next  = 4'd0;
                        end
                    end
                end
            endcase
        end

        // Idle time left, measured against the updated client time
        el_new  = (client_next == now_t) ? '0 : el_old;
        el_wide = WIDE'(el_new);

        step.radio_state   = mode_next;
        step.start_request = start_req;
        step.stop_reason   = reason;
        step.client_count  = seen_next;
        step.left_valid    = (mode_next == resq_pkg::MODE_SERVING) && (seen_next == 4'd0)
                             && (el_wide < WIDE'(cfg.idle_timeout_ms));
        step.left_ms       = cfg.idle_timeout_ms - el_wide[31:0];
    end

    // Hold state; advance on an accepted step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= resq_pkg::MODE_OFF;
            since_reg       <= '0;
            since_valid_reg <= 1'b0;
            latch_reg       <= 1'b0;
            poll_reg        <= '0;
            client_reg      <= '0;
            seen_reg        <= 4'd0;
        end
        else if (fire)
        begin
            mode_reg        <= mode_next;
            since_reg       <= since_next;
            since_valid_reg <= since_valid_next;
            latch_reg       <= latch_next;
            poll_reg        <= poll_next;
            client_reg      <= client_next;
            seen_reg        <= seen_next;
        end
    end

    `RESQ_ASSERT(a_latch_keeps_off, clk, rst_n, latch_reg |-> mode_reg == resq_pkg::MODE_OFF, "idle latch set while radio active")
    `RESQ_ASSERT(a_stop_goes_off, clk, rst_n, (fire && step.stop_reason != resq_pkg::STOP_NONE) |=> mode_reg == resq_pkg::MODE_OFF, "stop reported but mode not off")
    `RESQ_ASSERT(a_start_not_serving, clk, rst_n, (fire && step.start_request) |-> mode_reg != resq_pkg::MODE_SERVING, "start attempted while serving")
    `RESQ_ASSERT(a_clients_only_serving, clk, rst_n, (seen_reg != 4'd0) |-> mode_reg == resq_pkg::MODE_SERVING, "client count held outside serving")

endmodule

`default_nettype wire

// ===== src/radio_enable_idle_sequencer_unit.sv =====
// Radio enable idle sequencer: top level with configuration registers,
// item pipeline and idle-seconds stage. Depends on resq_pkg, resq_if, resq_seq.
//
// One tick item is accepted per clock cycle while the pipeline is not stalled; its result
// is offered after passing the input register, the sequencer step into the middle
// register and the divide-by-1000 stage into the result register. resq_seq updates
// the sequencer state per accepted step, so ticks may follow each other back to back;
// the idle seconds come from a single 32 x 29 reciprocal multiply in the last stage.
// Each stage holds its item while the next one is full, so a stalled result stops
// the input once all three stages are full. Configuration writes take effect at
// once and are meant for idle periods.
`timescale 1ns / 1ps
`default_nettype none

module radio_enable_idle_sequencer_unit #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [resq_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [resq_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    resq_if.sink                                       tick,
    resq_if.source                                     result
);

    resq_pkg::cfg_t           cfg_reg;
    logic                     in_valid_reg;
    resq_pkg::tick_item_t     in_data_reg;
    logic                     mid_valid_reg;
    resq_pkg::step_t          mid_reg;
    logic                     out_valid_reg;
    resq_pkg::result_item_t   out_data_reg;

    resq_pkg::step_t          step;
    logic                     out_ready;
    logic                     mid_ready;
    logic                     in_ready;
    logic                     fire;
    logic [resq_pkg::PROD_BITS-1:0] prod;
    logic [22:0]              left_sec;

    // Stage handshakes
    assign out_ready = !out_valid_reg || result.ready;
    assign mid_ready = !mid_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || mid_ready;
    assign fire      = in_valid_reg && mid_ready;

    assign tick.ready   = in_ready;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.service_enabled       <= 1'b0;
            cfg_reg.running_rpm_threshold <= resq_pkg::RST_RPM_THRESHOLD;
            cfg_reg.min_battery_mv        <= resq_pkg::RST_MIN_BATTERY;
            cfg_reg.arm_delay_ms          <= resq_pkg::RST_ARM_DELAY;
            cfg_reg.idle_timeout_ms       <= resq_pkg::RST_IDLE_TIMEOUT;
            cfg_reg.poll_interval_ms      <= resq_pkg::RST_POLL_INTERVAL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                resq_pkg::CFG_SERVICE_ENABLED: cfg_reg.service_enabled       <= cfg_data[0];
                resq_pkg::CFG_RPM_THRESHOLD:   cfg_reg.running_rpm_threshold <= cfg_data[13:0];
                resq_pkg::CFG_MIN_BATTERY:     cfg_reg.min_battery_mv        <= cfg_data[14:0];
                resq_pkg::CFG_ARM_DELAY:       cfg_reg.arm_delay_ms          <= cfg_data;
                resq_pkg::CFG_IDLE_TIMEOUT:    cfg_reg.idle_timeout_ms       <= cfg_data;
                resq_pkg::CFG_POLL_INTERVAL:   cfg_reg.poll_interval_ms      <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Sequencer step
    resq_seq #(
        .TIME_BITS (TIME_BITS)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_data_reg),
        .cfg   (cfg_reg),
        .step  (step)
    );

    // Milliseconds left to whole seconds
    assign prod     = resq_pkg::PROD_BITS'(mid_reg.left_ms) *
                      resq_pkg::PROD_BITS'(resq_pkg::RECIP_1000);
    assign left_sec = mid_reg.left_valid ? 23'(prod >> resq_pkg::RECIP_SHIFT) : 23'd0;

    // Pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= tick.valid;
            end
            if (mid_ready)
            begin
                mid_valid_reg <= in_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (tick.valid && in_ready)
        begin
            in_data_reg <= tick.data;
        end
        if (fire)
        begin
            mid_reg <= step;
        end
        if (mid_valid_reg && out_ready)
        begin
            out_data_reg.radio_state       <= mid_reg.radio_state;
            out_data_reg.start_request     <= mid_reg.start_request;
            out_data_reg.stop_reason       <= mid_reg.stop_reason;
            out_data_reg.idle_seconds_left <= left_sec;
            out_data_reg.client_count      <= mid_reg.client_count;
        end
    end

endmodule

`default_nettype wire
